FILE: hw/rtl/gtsc_pkg.sv
// ----------------------------------------------------------------------------
// Gimbal tracking step controller package
// Shared widths, register indexes, reset values and direction codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsc_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_DEADBAND      = 3'd2,
        CFG_STEP_GAIN     = 3'd3,
        CFG_MAX_STEPS     = 3'd4,
        CFG_TILT_SOFT_LIM = 3'd5,
        CFG_LOST_TIMEOUT  = 3'd6,
        CFG_SEARCH_STEPS  = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [11:0] RST_CENTER_X      = 12'd320;
    localparam logic [11:0] RST_CENTER_Y      = 12'd240;
    localparam logic [9:0]  RST_DEADBAND      = 10'd20;
    localparam logic [7:0]  RST_STEP_GAIN     = 8'd8;
    localparam logic [9:0]  RST_MAX_STEPS     = 10'd400;
    localparam logic [14:0] RST_TILT_SOFT_LIM = 15'd12800;
    localparam logic [15:0] RST_LOST_TIMEOUT  = 16'd300;
    localparam logic [9:0]  RST_SEARCH_STEPS  = 10'd200;

    // Saturation value of the elapsed millisecond counter
    localparam logic [15:0] MS_SAT = 16'hFFFF;

    // Last recorded direction of an axis
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    // Configuration register file
    typedef struct packed {
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [9:0]  deadband;
        logic [7:0]  step_gain;
        logic [9:0]  max_steps;
        logic [14:0] tilt_soft_lim;
        logic [15:0] lost_timeout_ms;
        logic [9:0]  search_steps;
    } t_cfg;

    // Result of one item
    typedef struct packed {
        logic               searching;
        logic signed [16:0] tilt_steps;
        logic               tilt_move;
        logic signed [10:0] pan_steps;
        logic               pan_move;
    } t_result;

endpackage : gtsc_pkg

`default_nettype wire

FILE: hw/rtl/gimbal_tracking_step_controller.sv
// ----------------------------------------------------------------------------
// Gimbal tracking step controller
// Turns target coordinate reports and millisecond ticks into relative step
// moves for a two-axis pan/tilt gimbal, with dead zone, gain, clamping, tilt
// soft limits and a search pattern after the target has been lost.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload
//  ---------  ---------  ----------------------------------------------------
//  s_axis     in         tuser: action; tdata: target_x, target_y, pan_busy,
//                        tilt_busy, tilt_position
//  m_axis     out        tdata: pan_move, pan_steps, tilt_move, tilt_steps,
//                        searching
//  cfg        in         write enable, register index, write data
//
//  The block takes one beat per clock cycle while m_axis does not stall. A
//  beat is captured in the input register and one combinational pass loads
//  the result register from it once that register is free or being emptied.
//  The result register stalls on m_axis backpressure and the input register
//  then holds one more beat before s_axis tready drops.
//  A synchronous active-low reset clears both valid flags, the elapsed counter,
//  the recorded directions and all configuration registers to their defaults.
//
`default_nettype none

module gimbal_tracking_step_controller
    import gtsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Input stream
    input  wire logic                  i_s_axis_tvalid,
    output      logic                  o_s_axis_tready,
    // [15:0] target_x, [31:16] target_y, [32] pan_busy, [33] tilt_busy,
    // [49:34] tilt_position, [55:50] zero
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] action (0 = coordinate report, 1 = millisecond tick)
    input  wire logic                  i_s_axis_tuser,

    // Result stream
    output      logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] pan_move, [11:1] pan_steps, [12] tilt_move, [29:13] tilt_steps,
    // [30] searching, [31] zero
    output      logic [M_TDATA_W-1:0]  o_m_axis_tdata,

    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x        <= RST_CENTER_X;
            r_cfg.center_y        <= RST_CENTER_Y;
            r_cfg.deadband        <= RST_DEADBAND;
            r_cfg.step_gain       <= RST_STEP_GAIN;
            r_cfg.max_steps       <= RST_MAX_STEPS;
            r_cfg.tilt_soft_lim   <= RST_TILT_SOFT_LIM;
            r_cfg.lost_timeout_ms <= RST_LOST_TIMEOUT;
            r_cfg.search_steps    <= RST_SEARCH_STEPS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CENTER_X:      r_cfg.center_x        <= i_cfg_wdata[11:0];
                CFG_CENTER_Y:      r_cfg.center_y        <= i_cfg_wdata[11:0];
                CFG_DEADBAND:      r_cfg.deadband        <= i_cfg_wdata[9:0];
                CFG_STEP_GAIN:     r_cfg.step_gain       <= i_cfg_wdata[7:0];
                CFG_MAX_STEPS:     r_cfg.max_steps       <= i_cfg_wdata[9:0];
                CFG_TILT_SOFT_LIM: r_cfg.tilt_soft_lim   <= i_cfg_wdata[14:0];
                CFG_LOST_TIMEOUT:  r_cfg.lost_timeout_ms <= i_cfg_wdata;
                CFG_SEARCH_STEPS:  r_cfg.search_steps    <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. The pass advances
    // when the input register is full and the result register is empty or being emptied.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic in_accept;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register payload
    logic               r_tick;
    logic signed [15:0] r_target_x;
    logic signed [15:0] r_target_y;
    logic               r_pan_busy;
    logic               r_tilt_busy;
    logic signed [15:0] r_tilt_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tick      <= i_s_axis_tuser;
            r_target_x  <= i_s_axis_tdata[15:0];
            r_target_y  <= i_s_axis_tdata[31:16];
            r_pan_busy  <= i_s_axis_tdata[32];
            r_tilt_busy <= i_s_axis_tdata[33];
            r_tilt_pos  <= i_s_axis_tdata[49:34];
        end
    end

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    logic [15:0] r_ms_since_report;
    t_dir        r_pan_dir;
    t_dir        r_tilt_dir;

    logic [15:0] n_ms_since_report;
    t_dir        n_pan_dir;
    t_dir        n_tilt_dir;
    t_result     n_result;

    // ------------------------------------------------------------------
    // Single combinational pass over the item in the input register
    // ------------------------------------------------------------------
    // Errors are 18 bits wide: a 16-bit signed coordinate minus a 12-bit
    // center never wraps. Products with the 8-bit gain fit in 27 bits.
    logic signed [17:0] err_x;
    logic signed [17:0] err_y;
    logic signed [17:0] neg_err_y;
    logic signed [17:0] dz_s;
    logic signed [26:0] prod_x;
    logic signed [26:0] prod_y;
    logic signed [26:0] max_s;
    logic signed [10:0] pan_clamp;
    logic signed [10:0] tilt_clamp;
    logic signed [17:0] lim_s;
    logic signed [17:0] pos_s;
    logic signed [17:0] tilt_trk;
    logic signed [17:0] tilt_trk_end;
    logic signed [17:0] search_s;
    logic signed [17:0] tilt_srch;
    logic signed [17:0] tilt_srch_end;
    logic               out_dz_x;
    logic               out_dz_y;
    logic               search_on;

    always_comb begin
        err_x     = 18'(r_target_x) - $signed({6'd0, r_cfg.center_x});
        err_y     = 18'(r_target_y) - $signed({6'd0, r_cfg.center_y});
        neg_err_y = -err_y;
        dz_s      = $signed({8'd0, r_cfg.deadband});
        out_dz_x  = (err_x > dz_s) || (err_x < -dz_s);
        out_dz_y  = (err_y > dz_s) || (err_y < -dz_s);

        prod_x = err_x * $signed({1'b0, r_cfg.step_gain});
        prod_y = neg_err_y * $signed({1'b0, r_cfg.step_gain});
        max_s  = $signed({17'd0, r_cfg.max_steps});

        // Clamp each tracking step to plus or minus max_steps
        if (prod_x > max_s) begin
            pan_clamp = max_s[10:0];
        end else if (prod_x < -max_s) begin
            pan_clamp = 11'(-max_s);
        end else begin
            pan_clamp = prod_x[10:0];
        end

        if (prod_y > max_s) begin
            tilt_clamp = max_s[10:0];
        end else if (prod_y < -max_s) begin
            tilt_clamp = 11'(-max_s);
        end else begin
            tilt_clamp = prod_y[10:0];
        end

        // A tracking tilt move that would pass a soft limit is cut to the
        // distance to that limit, which may point back into the range.
        lim_s        = $signed({3'd0, r_cfg.tilt_soft_lim});
        pos_s        = 18'(r_tilt_pos);
        tilt_trk_end = pos_s + 18'(tilt_clamp);
        if (tilt_trk_end > lim_s) begin
            tilt_trk = lim_s - pos_s;
        end else if (tilt_trk_end < -lim_s) begin
            tilt_trk = -lim_s - pos_s;
        end else begin
            tilt_trk = 18'(tilt_clamp);
        end

        // Search move of the tilt axis in its last direction
        search_s      = $signed({8'd0, r_cfg.search_steps});
        tilt_srch     = (r_tilt_dir == DIR_POS) ? search_s : -search_s;
        tilt_srch_end = pos_s + tilt_srch;

        // Elapsed counter saturates rather than wrapping
        n_ms_since_report = r_ms_since_report;
        if (r_tick && (r_ms_since_report != MS_SAT)) begin
            n_ms_since_report = r_ms_since_report + 16'd1;
        end
        search_on = r_tick && (n_ms_since_report > r_cfg.lost_timeout_ms);

        n_pan_dir  = r_pan_dir;
        n_tilt_dir = r_tilt_dir;
        n_result   = '0;

        if (!r_tick) begin
            // Coordinate report: restart the lost-target timer and track
            n_ms_since_report = '0;
            if (out_dz_x) begin
                n_pan_dir = (pan_clamp > 11'sd0) ? DIR_POS : DIR_NEG;
                if (!r_pan_busy) begin
                    n_result.pan_move  = 1'b1;
                    n_result.pan_steps = pan_clamp;
                end
            end
            if (out_dz_y) begin
                n_tilt_dir = (tilt_trk > 18'sd0) ? DIR_POS : DIR_NEG;
                if (!r_tilt_busy && (tilt_trk != 18'sd0)) begin
                    n_result.tilt_move  = 1'b1;
                    n_result.tilt_steps = tilt_trk[16:0];
                end
            end
        end else if (search_on) begin
            n_result.searching = 1'b1;
            if (!r_pan_busy && (r_pan_dir != DIR_NONE)) begin
                n_result.pan_move  = 1'b1;
                n_result.pan_steps = (r_pan_dir == DIR_POS)
                                     ? $signed({1'b0, r_cfg.search_steps})
                                     : -$signed({1'b0, r_cfg.search_steps});
            end
            if (!r_tilt_busy && (r_tilt_dir != DIR_NONE)) begin
                if ((tilt_srch_end <= lim_s) && (tilt_srch_end >= -lim_s)) begin
                    n_result.tilt_move  = 1'b1;
                    n_result.tilt_steps = tilt_srch[16:0];
                end else begin
                    // Bounce off the soft limit on the next search tick
                    n_tilt_dir = (r_tilt_dir == DIR_POS) ? DIR_NEG : DIR_POS;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_since_report <= '0;
            r_pan_dir         <= DIR_NONE;
            r_tilt_dir        <= DIR_NONE;
            r_out_valid       <= 1'b0;
        end else begin
            if (advance) begin
                r_ms_since_report <= n_ms_since_report;
                r_pan_dir         <= n_pan_dir;
                r_tilt_dir        <= n_tilt_dir;
                r_out_valid       <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_result};

endmodule : gimbal_tracking_step_controller

`default_nettype wire

FILE: hw/rtl/gtsc_checker.sv
// ----------------------------------------------------------------------------
// Gimbal tracking step controller checker
// Port-level assertions on result timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsc_checker
    import gtsc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    // A pending result is not withdrawn before it is taken.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Every accepted beat is followed by a valid result.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> ##2 o_m_axis_tvalid)
        else $error("no result two cycles after an input beat");

    // Step counts are zero on an axis that gets no move.
    a_idle_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[0] || (o_m_axis_tdata[11:1] == '0)) &&
             (o_m_axis_tdata[12] || (o_m_axis_tdata[29:13] == '0))))
        else $error("step count on an axis without a move");

    // A search tilt move never exceeds the 10-bit search distance.
    a_search_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[30] && o_m_axis_tdata[12]) |->
            ((o_m_axis_tdata[29:23] == 7'h00) || (o_m_axis_tdata[29:23] == 7'h7F)))
        else $error("search tilt move out of range");

endmodule : gtsc_checker

bind gimbal_tracking_step_controller gtsc_checker u_gtsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
